/* src/mbhs_pkg.sv */
// Package with shared types and constants of the media box header scanner.
`default_nettype none

package mbhs_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusSizeLow   = 2'd1;
  localparam logic [1:0] StatusTruncated = 2'd2;
  localparam logic [1:0] StatusOverrun   = 2'd3;

  localparam logic [3:0] IdxSizeEnd  = 4'd3;
  localparam logic [3:0] IdxShortEnd = 4'd7;
  localparam logic [3:0] IdxLargeBeg = 4'd8;
  localparam logic [3:0] IdxLargeEnd = 4'd15;
  localparam logic [63:0] LargeSizeMark = 64'd1;

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhDone    = 2'd2,
    PhHalted  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } word_t;

endpackage

`default_nettype wire

/* src/mbhs_front.sv */
// Front part: accepts stream words and queues them for the header parser.
`default_nettype none

module mbhs_front #(
  parameter int unsigned Depth = mbhs_pkg::QueueDepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire mbhs_pkg::word_t in_word_i,
  output logic               q_valid_o,
  input  wire logic          q_pop_i,
  output mbhs_pkg::word_t    q_word_o
);
  import mbhs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  word_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign in_stall_o = (count_q == CntFull);
  assign q_valid_o  = (count_q != '0);
  assign q_word_o   = mem_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_word_i;
    end
  end

endmodule

`default_nettype wire

/* src/mbhs_back.sv */
// Back part: box header parser with payload skip and a registered result word.
`default_nettype none

module mbhs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  output logic                 q_pop_o,
  input  wire mbhs_pkg::word_t q_word_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [63:0]          box_offset_o,
  output logic [63:0]          box_size_o,
  output logic [31:0]          box_type_o,
  output logic [4:0]           header_length_o,
  output logic [1:0]           status_o
);
  import mbhs_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [63:0] offset_q, offset_d;
  logic [63:0] start_q, start_d;
  logic [63:0] size_q, size_d;
  logic [31:0] type_q, type_d;
  logic [63:0] left_q, left_d;

  logic        out_valid_q, out_valid_d;
  logic [63:0] o_offset_q, o_offset_d;
  logic [63:0] o_size_q, o_size_d;
  logic [31:0] o_type_q, o_type_d;
  logic [4:0]  o_hlen_q, o_hlen_d;
  logic [1:0]  o_status_q, o_status_d;

  logic        take;
  logic        emit;
  logic [63:0] size_new;
  logic [31:0] type_new;
  logic [63:0] offset_inc;
  logic [4:0]  hlen;
  logic [63:0] left_new;
  logic [63:0] left_dec;
  logic        complete;
  logic        eos;
  logic [7:0]  b;

  assign take      = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o   = take;
  assign eos       = q_word_i.end_of_stream;
  assign b         = q_word_i.data_byte;
  assign offset_inc = offset_q + 64'd1;
  assign hlen      = {1'b0, idx_q} + 5'd1;

  always_comb begin
    size_new = size_q;
    type_new = type_q;
    if (idx_q <= IdxSizeEnd) begin
      size_new = {size_q[55:0], b};
    end else if (idx_q <= IdxShortEnd) begin
      type_new = {type_q[23:0], b};
    end else if (idx_q == IdxLargeBeg) begin
      size_new = {56'd0, b};
    end else begin
      size_new = {size_q[55:0], b};
    end
  end

  assign complete = ((idx_q == IdxShortEnd) && (size_new != LargeSizeMark)) ||
                    (idx_q == IdxLargeEnd);
  assign left_new = size_new - {59'd0, hlen};
  assign left_dec = (left_q != '0) ? left_q - 64'd1 : '0;

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    offset_d   = offset_q;
    start_d    = start_q;
    size_d     = size_q;
    type_d     = type_q;
    left_d     = left_q;
    emit       = 1'b0;
    o_offset_d = o_offset_q;
    o_size_d   = o_size_q;
    o_type_d   = o_type_q;
    o_hlen_d   = o_hlen_q;
    o_status_d = o_status_q;
    if (take) begin
      unique case (phase_q)
        PhHeader: begin
          offset_d   = offset_inc;
          size_d     = size_new;
          type_d     = type_new;
          o_offset_d = start_q;
          o_size_d   = size_new;
          o_type_d   = type_new;
          o_hlen_d   = hlen;
          o_status_d = StatusOk;
          if (!complete) begin
            idx_d = idx_q + 4'd1;
            if (eos) begin
              emit       = 1'b1;
              o_size_d   = '0;
              o_type_d   = '0;
              o_hlen_d   = '0;
              o_status_d = StatusTruncated;
              phase_d    = PhHalted;
            end
          end else if (size_new < {59'd0, hlen}) begin
            emit       = 1'b1;
            o_status_d = StatusSizeLow;
            phase_d    = PhHalted;
          end else if (left_new == '0) begin
            emit = 1'b1;
            if (eos) begin
              phase_d = PhDone;
            end else begin
              phase_d = PhHeader;
              idx_d   = '0;
              start_d = offset_inc;
              size_d  = '0;
              type_d  = '0;
              left_d  = '0;
            end
          end else if (eos) begin
            emit       = 1'b1;
            o_status_d = StatusOverrun;
            phase_d    = PhHalted;
          end else begin
            emit    = 1'b1;
            left_d  = left_new;
            phase_d = PhPayload;
          end
        end
        PhPayload: begin
          offset_d = offset_inc;
          left_d   = left_dec;
          if (left_dec == '0) begin
            if (eos) begin
              phase_d = PhDone;
            end else begin
              phase_d = PhHeader;
              idx_d   = '0;
              start_d = offset_inc;
              size_d  = '0;
              type_d  = '0;
              left_d  = '0;
            end
          end else if (eos) begin
            emit       = 1'b1;
            o_offset_d = start_q;
            o_size_d   = size_q;
            o_type_d   = type_q;
            o_hlen_d   = hlen;
            o_status_d = StatusOverrun;
            phase_d    = PhHalted;
          end
        end
        default: begin
        end
      endcase
    end
    if (take && emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHeader;
      idx_q       <= '0;
      offset_q    <= '0;
      start_q     <= '0;
      size_q      <= '0;
      type_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      idx_q       <= idx_d;
      offset_q    <= offset_d;
      start_q     <= start_d;
      size_q      <= size_d;
      type_q      <= type_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      o_offset_q <= o_offset_d;
      o_size_q   <= o_size_d;
      o_type_q   <= o_type_d;
      o_hlen_q   <= o_hlen_d;
      o_status_q <= o_status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign box_offset_o    = o_offset_q;
  assign box_size_o      = o_size_q;
  assign box_type_o      = o_type_q;
  assign header_length_o = o_hlen_q;
  assign status_o        = o_status_q;

endmodule

`default_nettype wire

/* src/media_box_header_scanner.sv */
// Top level of the media box header scanner: input queue and header parser.
//
// The input channel takes one stream word per cycle unless in_stall_o is
// high: a data byte and an end-of-stream flag that marks the last byte of
// the buffer. The output channel gives one word per complete box header,
// and a word for each error. Both channels accept a word at a clock edge with
// valid high and stall low. A byte accepted at one edge waits in the input
// queue until the parser takes it, and the parser registers its result word.
// The parser takes one byte per cycle while the queue holds a byte and no
// stalled result is pending, so the throughput is then one byte per clock.
// When the receiver stalls a pending result, the result holds, the parser
// waits, and the input queue of QueueDepth words fills before in_stall_o rises.
// Reset clears the queue, the parser state and the stream offset, and the
// parser starts waiting for the first box header. After an error or a clean
// end of stream, further bytes are accepted and dropped until reset.
`default_nettype none

module media_box_header_scanner #(
  parameter int unsigned QueueDepth = mbhs_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_stream_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      box_offset_o,
  output logic [63:0]      box_size_o,
  output logic [31:0]      box_type_o,
  output logic [4:0]       header_length_o,
  output logic [1:0]       status_o
);
  import mbhs_pkg::*;

  word_t in_word;
  word_t q_word;
  logic  q_valid;
  logic  q_pop;

  assign in_word = '{data_byte: data_byte_i, end_of_stream: end_of_stream_i};

  mbhs_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i (in_word),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_word_o  (q_word)
  );

  mbhs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .q_word_i       (q_word),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .box_offset_o   (box_offset_o),
    .box_size_o     (box_size_o),
    .box_type_o     (box_type_o),
    .header_length_o(header_length_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

/* tb/tb_media_box_header_scanner.sv */
// Testbench for the media box header scanner: box streams against a scoreboard model.
`default_nettype none

module tb_media_box_header_scanner;
  import mbhs_pkg::*;

  localparam int IdleLimit = 3000;
  localparam int HoldCycles = 300;
  localparam int DrainAt = 250;
  localparam int HoldAt = 400;
  localparam int CalmFrom = 120;
  localparam int CalmTo = 240;
  localparam int StreamBytes = 600;
  localparam int TrailerWords = 12;

  typedef enum int {
    EndCleanPayload,
    EndCleanHeader,
    EndTruncated,
    EndSizeLow,
    EndOverrunHeader,
    EndOverrunPayload
  } stream_end_e;

  typedef struct packed {
    logic [63:0] offset;
    logic [63:0] size;
    logic [31:0] box_type;
    logic [4:0]  hlen;
    logic [1:0]  status;
  } box_rec_t;

  class box_scoreboard;
    phase_e      phase;
    logic [3:0]  hdr_idx;
    logic [63:0] offset;
    logic [63:0] box_start;
    logic [63:0] size_acc;
    logic [63:0] bytes_left;
    logic [31:0] type_acc;
    box_rec_t    expected_q[$];
    int          mismatches;
    int          checked;
    int          status_seen[4];

    function new();
      offset = '0;
      open_box();
      mismatches = 0;
      checked = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    function void open_box();
      phase = PhHeader;
      hdr_idx = '0;
      box_start = offset;
      size_acc = '0;
      type_acc = '0;
      bytes_left = '0;
    endfunction

    function void expect_box(logic [63:0] size, logic [31:0] typ, logic [4:0] hlen,
                             logic [1:0] st);
      box_rec_t r;
      r.offset = box_start;
      r.size = size;
      r.box_type = typ;
      r.hlen = hlen;
      r.status = st;
      expected_q.push_back(r);
    endfunction

    function void note_word(word_t w);
      logic [3:0]  idx;
      logic [4:0]  hlen;
      logic [63:0] left;
      logic        complete;
      case (phase)
        PhHeader: begin
          idx = hdr_idx;
          if (idx <= IdxSizeEnd) begin
            size_acc = {size_acc[55:0], w.data_byte};
          end else if (idx <= IdxShortEnd) begin
            type_acc = {type_acc[23:0], w.data_byte};
          end else if (idx == IdxLargeBeg) begin
            size_acc = {56'd0, w.data_byte};
          end else begin
            size_acc = {size_acc[55:0], w.data_byte};
          end
          offset = offset + 64'd1;
          complete = (idx == IdxShortEnd && size_acc != LargeSizeMark) || idx == IdxLargeEnd;
          if (!complete) begin
            hdr_idx = idx + 4'd1;
            if (w.end_of_stream) begin
              expect_box('0, '0, '0, StatusTruncated);
              phase = PhHalted;
            end
          end else begin
            hlen = {1'b0, idx} + 5'd1;
            if (size_acc < {59'd0, hlen}) begin
              expect_box(size_acc, type_acc, hlen, StatusSizeLow);
              phase = PhHalted;
            end else begin
              left = size_acc - {59'd0, hlen};
              if (left == 64'd0) begin
                expect_box(size_acc, type_acc, hlen, StatusOk);
                if (w.end_of_stream) phase = PhDone;
                else open_box();
              end else if (w.end_of_stream) begin
                expect_box(size_acc, type_acc, hlen, StatusOverrun);
                phase = PhHalted;
              end else begin
                expect_box(size_acc, type_acc, hlen, StatusOk);
                bytes_left = left;
                phase = PhPayload;
              end
            end
          end
        end
        PhPayload: begin
          if (bytes_left != 64'd0) bytes_left = bytes_left - 64'd1;
          offset = offset + 64'd1;
          if (bytes_left == 64'd0) begin
            if (w.end_of_stream) phase = PhDone;
            else open_box();
          end else if (w.end_of_stream) begin
            expect_box(size_acc, type_acc, {1'b0, hdr_idx} + 5'd1, StatusOverrun);
            phase = PhHalted;
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_box(box_rec_t got);
      box_rec_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected box report: offset %h size %h type %h hlen %0d status %0d",
                   got.offset, got.size, got.box_type, got.hlen, got.status);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.offset !== want.offset || got.size !== want.size ||
          got.box_type !== want.box_type || got.hlen !== want.hlen ||
          got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch expected: offset %h size %h type %h hlen %0d status %0d",
                   want.offset, want.size, want.box_type, want.hlen, want.status);
          $display("         actual:   offset %h size %h type %h hlen %0d status %0d",
                   got.offset, got.size, got.box_type, got.hlen, got.status);
        end
      end else begin
        status_seen[got.status]++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data = 8'd0;
  logic        in_eos = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [63:0] box_offset;
  logic [63:0] box_size;
  logic [31:0] box_type;
  logic [4:0]  header_length;
  logic [1:0]  status;

  box_scoreboard sb;
  word_t         stream_q[$];
  int            box_count;
  int            idle_cycles = 0;
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;
  bit            hold_done = 1'b0;
  string         end_name;

  media_box_header_scanner dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (in_data),
    .end_of_stream_i(in_eos),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .box_offset_o   (box_offset),
    .box_size_o     (box_size),
    .box_type_o     (box_type),
    .header_length_o(header_length),
    .status_o       (status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void add_bytes(input logic [63:0] v, input int n);
    for (int k = n - 1; k >= 0; k--) begin
      stream_q.push_back('{data_byte: v[8*k +: 8], end_of_stream: 1'b0});
    end
  endfunction

  function automatic void add_box(input bit long_hdr, input logic [63:0] size,
                                  input logic [31:0] typ, input int pay);
    if (long_hdr) begin
      add_bytes(LargeSizeMark, 4);
      add_bytes({32'd0, typ}, 4);
      add_bytes(size, 8);
    end else begin
      add_bytes(size, 4);
      add_bytes({32'd0, typ}, 4);
    end
    for (int k = 0; k < pay; k++) add_bytes(64'($urandom_range(0, 255)), 1);
    box_count++;
  endfunction

  function automatic void mark_end();
    word_t w;
    w = stream_q.pop_back();
    w.end_of_stream = 1'b1;
    stream_q.push_back(w);
  endfunction

  task automatic build_stream();
    int          r;
    int          hl;
    int          pay;
    int          start;
    int          cut;
    bit          long_hdr;
    logic [63:0] size;
    stream_end_e ending;
    word_t       w;
    box_count = 0;
    add_box(1'b0, 64'd8, 32'hFFFF_FFFF, 0);
    add_box(1'b1, 64'd16, 32'h0000_0000, 0);
    while (stream_q.size() < StreamBytes) begin
      r = $urandom_range(0, 9);
      long_hdr = (r < 2);
      hl = long_hdr ? 16 : 8;
      pay = (r < 5) ? 0 : (r == 9) ? $urandom_range(25, 80) : $urandom_range(1, 24);
      add_box(long_hdr, 64'(hl + pay), $urandom, pay);
    end
    long_hdr = 1'($urandom_range(0, 1));
    hl = long_hdr ? 16 : 8;
    ending = stream_end_e'($urandom_range(0, 5));
    case (ending)
      EndCleanPayload: begin
        end_name = "a clean end after a payload";
        pay = $urandom_range(1, 20);
        add_box(long_hdr, 64'(hl + pay), $urandom, pay);
        mark_end();
      end
      EndCleanHeader: begin
        end_name = "a clean end on a header";
        add_box(long_hdr, 64'(hl), $urandom, 0);
        mark_end();
      end
      EndTruncated: begin
        end_name = "a truncated header";
        start = stream_q.size();
        add_box(long_hdr, 64'(hl + $urandom_range(0, 20)), $urandom, 0);
        cut = $urandom_range(1, hl - 1);
        while (stream_q.size() > start + cut) w = stream_q.pop_back();
        mark_end();
      end
      EndSizeLow: begin
        end_name = "a size below the header length";
        if (long_hdr) begin
          size = 64'($urandom_range(0, 15));
        end else begin
          size = 64'($urandom_range(0, 6));
          if (size == LargeSizeMark) size = 64'd7;
        end
        add_box(long_hdr, size, $urandom, 0);
      end
      EndOverrunHeader: begin
        end_name = "an overrun on the header byte";
        if ($urandom_range(0, 1)) size = long_hdr ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF;
        else size = 64'(hl + $urandom_range(1, 9));
        add_box(long_hdr, size, $urandom, 0);
        mark_end();
      end
      default: begin
        end_name = "an overrun in the payload";
        pay = $urandom_range(1, 30);
        if ($urandom_range(0, 1)) size = long_hdr ? 64'hFFFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF;
        else size = 64'(hl + pay + $urandom_range(1, 50));
        add_box(long_hdr, size, $urandom, pay);
        mark_end();
      end
    endcase
    for (int k = 0; k < TrailerWords; k++) begin
      stream_q.push_back('{data_byte: 8'($urandom), end_of_stream: 1'($urandom)});
    end
    mark_end();
  endtask

  task automatic send_word(input word_t w);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w.data_byte;
    in_eos <= w.end_of_stream;
    do @(posedge clk); while (in_stall);
    sb.note_word(w);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        hold_done = 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 19);
      end
    end
  end

  always @(posedge clk) begin
    box_rec_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.offset = box_offset;
      got.size = box_size;
      got.box_type = box_type;
      got.hlen = header_length;
      got.status = status;
      sb.check_box(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_media_box_header_scanner failed");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    build_stream();
    for (int i = 0; i < stream_q.size(); i++) begin
      calm = (i >= CalmFrom && i < CalmTo);
      if (i == DrainAt) begin
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
      end
      if (i == HoldAt) hold_req = 1'b1;
      send_word(stream_q[i]);
    end
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Scanned %0d stream bytes in %0d boxes; %0d reports checked (ok %0d, %0d %0d %0d).",
             stream_q.size(), box_count, sb.checked, sb.status_seen[StatusOk],
             sb.status_seen[StatusSizeLow], sb.status_seen[StatusTruncated],
             sb.status_seen[StatusOverrun]);
    $display("The stream closed with %s, then %0d bytes were sent to the stopped scanner.",
             end_name, TrailerWords);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_media_box_header_scanner passed");
    end else begin
      $display("tb_media_box_header_scanner failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
